### design/sarde_pkg.sv
// Package for the signed add radix digit emitter.
// Shared widths, ASCII constants, control/status structs and the digit-to-char function.
// No dependencies.
package sarde_pkg;

    localparam int unsigned MAG_W   = 64;  // operand and magnitude width
    localparam int unsigned BASE_W  = 6;   // base register and digit width
    localparam int unsigned CHAR_W  = 7;   // ASCII character width
    localparam int unsigned DIV_CNT_W = 6; // one count per magnitude bit

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0] LETTER_OFFSET = 7'd55;  // 'A' - 10
    localparam logic [BASE_W-1:0] DIGIT_NINE    = 6'd9;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_SUB = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the operands of an accepted transfer
        logic prep;      // form sign and magnitude, clear digit count
        logic div_step;  // one restoring division step
        logic store;     // write the remainder digit, start the next digit
        logic rd_issue;  // read the digit memory
        logic out_load;  // load the output register from the read data
        logic out_ovf;   // load the output register with the overflow result
        logic rd_next;   // move to the next less significant digit
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic ovf;       // magnitude reached 2^64
        logic quot_zero; // quotient after the current division is zero
        logic cnt_full;  // digit memory is full after this store
        logic rd_last;   // read pointer is at the least significant digit
    } t_status;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d > DIGIT_NINE) begin
            return dx + LETTER_OFFSET;
        end
        return dx + CHAR_ZERO;
    endfunction

endpackage

### design/sarde_if.sv
// Valid/ready channel interfaces for operands in and digits out.
// Depends on sarde_pkg for field widths.
interface sarde_in_if import sarde_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [MAG_W-1:0] operand_a;
    logic [MAG_W-1:0] operand_b;

    modport source (output valid, output req_type, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input req_type, input operand_a, input operand_b,
                    output ready);
endinterface

interface sarde_out_if import sarde_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              negative;
    logic              overflow;
    logic              is_last;

    modport source (output valid, output digit_char, output negative, output overflow,
                    output is_last, input ready);
    modport sink   (input valid, input digit_char, input negative, input overflow,
                    input is_last, output ready);
endinterface

### design/signed_add_radix_digit_emitter.sv
// Top level of the signed add radix digit emitter: config register, controller, datapath.
// Depends on sarde_pkg, sarde_if, sarde_ctrl and sarde_dp.
//
// Usage:
//   i_in  (sink)  : one transfer carries req_type, operand_a, operand_b. req_type 0 adds,
//                   1 subtracts operand_b from operand_a; both are 64-bit two's complement.
//   o_out (source): one transfer per digit of the result magnitude, most significant first,
//                   as ASCII '0'-'9' / 'A'-'Z', with negative, overflow and is_last.
//                   A zero result gives a single unsigned "0". A magnitude of 2^64 gives
//                   one transfer with overflow and is_last set and digit_char '0'.
//   APB port      : register 0 (byte addresses 0-3) is the base, 6 bits, reset 10. Values
//                   below 2 act as 2, above 36 as 36. Other addresses read 0, ignore writes.
// Sequencing:
//   One operand transfer is taken at a time; ready is high only while idle.
//   The magnitude is formed first, then each digit is found by the bit-serial divider,
//   which retires one quotient bit per cycle over all 64 magnitude bits, then a store step.
//   Each digit is then read out through memory read, output load and transfer, the
//   transfer completing when the receiver is ready.
// Reset (synchronous, active low) returns to idle, drops o_out.valid and sets base 10.
// A stalled receiver simply holds the current digit in the output register.
module signed_add_radix_digit_emitter import sarde_pkg::*; #(
    parameter int unsigned MAX_DIGITS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sarde_in_if.sink     i_in,
    sarde_out_if.source  o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic REG_BASE = 1'b0;  // word index of the base register

    logic [BASE_W-1:0] r_base;
    logic [BASE_W-1:0] eff_base;
    logic              cfg_wr;
    t_cmd              cmd;
    t_status           status;

    // APB: no wait states, word index is paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_BASE) ? {{(32 - BASE_W){1'b0}}, r_base} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (cfg_wr && (paddr[2] == REG_BASE)) begin
            r_base <= pwdata[BASE_W-1:0];
        end
    end

    // clamp to the supported range
    always_comb begin
        if (r_base < BASE_MIN) begin
            eff_base = BASE_MIN;
        end else if (r_base > BASE_MAX) begin
            eff_base = BASE_MAX;
        end else begin
            eff_base = r_base;
        end
    end

    sarde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sarde_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_base       (eff_base),
        .i_req_type   (i_in.req_type),
        .i_operand_a  (i_in.operand_a),
        .i_operand_b  (i_in.operand_b),
        .o_digit_char (o_out.digit_char),
        .o_negative   (o_out.negative),
        .o_overflow   (o_out.overflow),
        .o_is_last    (o_out.is_last)
    );

endmodule

### design/sarde_ctrl.sv
// Controller state machine: sequences load, magnitude, digit division and emission.
// Depends on sarde_pkg (t_cmd, t_status).
module sarde_ctrl import sarde_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_DIV, S_STORE, S_READ, S_LOAD, S_SEND
    } t_state;

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  out_xfer;

    assign out_xfer    = r_out_valid && i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_bit_cnt   = r_bit_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
                n_bit_cnt  = '0;
            end
            S_DIV: begin
                if (i_status.ovf) begin
                    o_cmd.out_ovf = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_SEND;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_bit_cnt      = r_bit_cnt + 1'b1;
                    if (r_bit_cnt == '1) begin
                        n_state = S_STORE;
                    end
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_bit_cnt   = '0;
                if (i_status.quot_zero || i_status.cnt_full) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = S_SEND;
            end
            S_SEND: begin
                if (out_xfer) begin
                    n_out_valid = 1'b0;
                    if (i_status.ovf || i_status.rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit_cnt   <= n_bit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### design/sarde_dp.sv
// Datapath: sign/magnitude add, bit-serial divider by the base, digit memory, output register.
// Depends on sarde_pkg (widths, t_cmd, t_status, digit_to_char).
module sarde_dp import sarde_pkg::*; #(
    parameter int unsigned MAX_DIGITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [BASE_W-1:0] i_base,
    input  logic              i_req_type,
    input  logic [MAG_W-1:0]  i_operand_a,
    input  logic [MAG_W-1:0]  i_operand_b,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic              o_negative,
    output logic              o_overflow,
    output logic              o_is_last
);

    localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DIGITS);

    // operand capture
    logic             r_sub;
    logic [MAG_W-1:0] r_a, r_b;

    // working state
    logic             r_ovf;
    logic             r_neg;
    logic [MAG_W-1:0] r_quo;
    logic [BASE_W-1:0] r_rem;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    r_rd_idx;
    logic [BASE_W-1:0] r_rd_data;

    logic [BASE_W-1:0] digit_mem [MAX_DIGITS];

    // sign and magnitude
    logic             sa, sb;
    logic [MAG_W-1:0] ma, mb;
    logic [MAG_W:0]   sum;
    logic             a_ge_b;
    logic [MAG_W-1:0] mag;
    logic             neg;

    always_comb begin
        sa     = r_a[MAG_W-1];
        sb     = r_b[MAG_W-1] ^ (r_sub == REQ_SUB);
        ma     = r_a[MAG_W-1] ? (~r_a + 1'b1) : r_a;
        mb     = r_b[MAG_W-1] ? (~r_b + 1'b1) : r_b;
        sum    = {1'b0, ma} + {1'b0, mb};
        a_ge_b = (ma >= mb);
        if (sa == sb) begin
            mag = sum[MAG_W-1:0];
            neg = sa;
        end else if (a_ge_b) begin
            mag = ma - mb;
            neg = sa;
        end else begin
            mag = mb - ma;
            neg = sb;
        end
    end

    // restoring division step: shift in the next dividend bit, subtract if it fits
    logic [BASE_W:0]   shifted;
    logic [BASE_W+1:0] trial;
    logic              fits;
    logic [CW-1:0]     cnt_inc;

    assign shifted = {r_rem, r_quo[MAG_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, i_base};
    assign fits    = !trial[BASE_W+1];
    assign cnt_inc = r_cnt + 1'b1;

    assign o_status.ovf       = r_ovf;
    assign o_status.quot_zero = (r_quo == '0);
    assign o_status.cnt_full  = (cnt_inc >= CNT_MAX);
    assign o_status.rd_last   = (r_rd_idx == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sub <= i_req_type;
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
        end
        if (i_cmd.prep) begin
            r_quo <= mag;
            r_rem <= '0;
            // a zero result is never negative; the carry only counts on a true add
            r_neg <= neg && (((sa == sb) && sum[MAG_W]) || (mag != '0));
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[MAG_W-2:0], fits};
            r_rem <= fits ? trial[BASE_W-1:0] : shifted[BASE_W-1:0];
        end else if (i_cmd.store) begin
            r_rem <= '0;
        end
        if (i_cmd.store) begin
            digit_mem[r_cnt[AW-1:0]] <= r_rem;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= digit_mem[r_rd_idx];
        end
        if (i_cmd.out_ovf) begin
            o_digit_char <= CHAR_ZERO;
            o_negative   <= r_neg;
            o_overflow   <= 1'b1;
            o_is_last    <= 1'b1;
        end else if (i_cmd.out_load) begin
            o_digit_char <= digit_to_char(r_rd_data);
            o_negative   <= r_neg;
            o_overflow   <= 1'b0;
            o_is_last    <= (r_rd_idx == '0);
        end
    end

    // control state: overflow flag, digit count, read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf    <= 1'b0;
            r_cnt    <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.prep) begin
                r_ovf <= (sa == sb) && sum[MAG_W];
                r_cnt <= '0;
            end
            if (i_cmd.store) begin
                r_cnt    <= cnt_inc;
                r_rd_idx <= r_cnt[AW-1:0];
            end else if (i_cmd.rd_next) begin
                r_rd_idx <= r_rd_idx - 1'b1;
            end
        end
    end

endmodule
